FILE: design/alarm_table_scheduler_assert.svh
// Assertion macros for the alarm table checker.
// Each macro expects signals named clock and reset in the scope of its use.
`ifndef ALARM_TABLE_SCHEDULER_ASSERT_SVH
`define ALARM_TABLE_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("alarm table scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define ATS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("alarm table scheduler check failed");

`endif

FILE: design/ats_pkg.sv
`default_nettype none

package ats_pkg;

   // Operation codes of a request word.
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_ACTIVATE = 2'd1;
   localparam logic [1:0] OP_CANCEL   = 2'd2;
   localparam logic [1:0] OP_IGNORED  = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  event_id;
      logic [30:0] delay;
      logic        periodic;
      logic [31:0] aux_data;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  fired_event;
      logic [31:0] fired_data;
      logic        overflow;
      logic        last;
   } rsp_word_type;

   // One slot of the alarm table as it sits in memory.
   typedef struct packed {
      logic [7:0]  event_id;
      logic [31:0] data;
      logic        periodic;
      logic [30:0] period;
      logic [31:0] due;
   } slot_entry_type;

   // What the table scan does with each slot.
   typedef enum logic [1:0] {
      JOB_TICK,
      JOB_ARM,
      JOB_CLEAR
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

`default_nettype wire

FILE: design/ats_ram.sv
`default_nettype none

module ats_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/alarm_table_scheduler.sv
// Alarm table scheduler: a table of NUM_SLOTS alarms against a 32-bit tick count.
// Each accepted word is handled by one scan of the slot memory, one slot read per cycle while
// it does not stall, and the block takes no new word until the scan and its finish are done;
// the scan stalls while a fired alarm waits for the result register. An ignored word starts no scan.
// Results of a tick lag one fired slot behind; the last one leaves in the finishing state.
// Synchronous active-high reset clears every alarm, the tick count and all pending results.
`default_nettype none

module alarm_table_scheduler #(
   parameter int NUM_SLOTS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire ats_pkg::req_word_type req_word,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output ats_pkg::rsp_word_type     rsp_word
);

   localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
   localparam int ENTRY_W = $bits(ats_pkg::slot_entry_type);

   // Control state.
   ats_pkg::state_type state_ff, state_in;
   logic [31:0]        tick_count_ff, tick_count_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [CNT_W-1:0]   issue_cnt_ff, issue_cnt_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               found_valid_ff, found_valid_in;
   logic               free_valid_ff, free_valid_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload state.
   ats_pkg::job_type      job_ff, job_in;
   ats_pkg::req_word_type cmd_ff, cmd_in;
   logic [IDX_W-1:0]      s1_idx_ff, s1_idx_in;
   logic [IDX_W-1:0]      found_idx_ff, found_idx_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   ats_pkg::rsp_word_type pend_ff, pend_in;
   ats_pkg::rsp_word_type rsp_ff, rsp_in;

   // Slot memory ports.
   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   logic [ENTRY_W-1:0]      ram_wr_data;
   logic                    ram_rd_en;
   logic [IDX_W-1:0]        ram_rd_addr;
   logic [ENTRY_W-1:0]      ram_rd_data;
   ats_pkg::slot_entry_type entry_rd;
   ats_pkg::slot_entry_type entry_wr;

   logic                  accept;
   logic                  out_free;
   logic                  s1_active;
   logic                  s1_hit;
   logic                  s1_fire;
   logic                  stall;
   logic [IDX_W-1:0]      target_idx;
   ats_pkg::rsp_word_type fire_word;
   ats_pkg::rsp_word_type ovf_word;

   // All slot fields but the active flag live in one memory. The active flags stay in
   // flip-flops so that reset empties the table at once; a slot that was never armed is
   // never active, so its undefined memory contents are never used.
   ats_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign entry_rd  = ats_pkg::slot_entry_type'(ram_rd_data);
   assign req_ready = (state_ff == ats_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Stage one sees the slot that was read in the previous cycle. During the scan, writes only
   // go to that slot, while the read port has moved on to the next one, so the scan never reads
   // a slot in the cycle it is written.
   assign s1_active  = active_ff[s1_idx_ff];
   assign s1_hit     = (entry_rd.event_id == cmd_ff.event_id);
   assign s1_fire    = s1_valid_ff && (job_ff == ats_pkg::JOB_TICK) && s1_active &&
                       (entry_rd.due == tick_count_ff);
   // A fired alarm is parked in the pending register; the one parked before it must move
   // to the result register, and if that is still full the scan waits. The read port is
   // held too, so the memory output keeps the slot under test.
   assign stall      = s1_fire && pend_valid_ff && !out_free;
   assign target_idx = found_valid_ff ? found_idx_ff : free_idx_ff;

   always_comb begin
      fire_word             = '0;
      fire_word.fired_event = entry_rd.event_id;
      fire_word.fired_data  = entry_rd.data;
      ovf_word              = '0;
      ovf_word.overflow     = 1'b1;
      ovf_word.last         = 1'b1;
   end

   always_comb begin
      state_in       = state_ff;
      tick_count_in  = tick_count_ff;
      active_in      = active_ff;
      issue_cnt_in   = issue_cnt_ff;
      s1_valid_in    = s1_valid_ff;
      found_valid_in = found_valid_ff;
      free_valid_in  = free_valid_ff;
      pend_valid_in  = pend_valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      job_in         = job_ff;
      cmd_in         = cmd_ff;
      s1_idx_in      = s1_idx_ff;
      found_idx_in   = found_idx_ff;
      free_idx_in    = free_idx_ff;
      pend_in        = pend_ff;
      rsp_in         = rsp_ff;

      // By default a write goes back to the slot under test with its due time moved on by
      // one period, which is what a periodic alarm needs when it fires.
      entry_wr       = entry_rd;
      entry_wr.due   = entry_rd.due + {1'b0, entry_rd.period};
      ram_wr_en      = 1'b0;
      ram_wr_addr    = s1_idx_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = issue_cnt_ff[IDX_W-1:0];

      case (state_ff)
         ats_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in         = req_word;
               issue_cnt_in   = '0;
               s1_valid_in    = 1'b0;
               found_valid_in = 1'b0;
               free_valid_in  = 1'b0;
               pend_valid_in  = 1'b0;
               case (req_word.operation)
                  ats_pkg::OP_TICK: begin
                     job_in        = ats_pkg::JOB_TICK;
                     tick_count_in = tick_count_ff + 32'd1;
                     state_in      = ats_pkg::ST_SCAN;
                  end
                  ats_pkg::OP_ACTIVATE: begin
                     // A zero delay is a plain cancel of the event.
                     job_in   = (req_word.delay == '0) ? ats_pkg::JOB_CLEAR
                                                       : ats_pkg::JOB_ARM;
                     state_in = ats_pkg::ST_SCAN;
                  end
                  ats_pkg::OP_CANCEL: begin
                     job_in   = ats_pkg::JOB_CLEAR;
                     state_in = ats_pkg::ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ats_pkg::ST_SCAN: begin
            if (!stall) begin
               if (s1_valid_ff) begin
                  case (job_ff)
                     ats_pkg::JOB_TICK: begin
                        if (s1_fire) begin
                           if (pend_valid_ff) begin
                              rsp_valid_in = 1'b1;
                              rsp_in       = pend_ff;
                           end
                           pend_valid_in = 1'b1;
                           pend_in       = fire_word;
                           if (entry_rd.periodic) begin
                              ram_wr_en = 1'b1;
                           end else begin
                              active_in[s1_idx_ff] = 1'b0;
                           end
                        end
                     end
                     ats_pkg::JOB_ARM: begin
                        // Remember the first active slot of this event and the first
                        // free slot; the event's own slot wins at the end.
                        if (s1_active) begin
                           if (s1_hit && !found_valid_ff) begin
                              found_valid_in = 1'b1;
                              found_idx_in   = s1_idx_ff;
                           end
                        end else if (!free_valid_ff) begin
                           free_valid_in = 1'b1;
                           free_idx_in   = s1_idx_ff;
                        end
                     end
                     ats_pkg::JOB_CLEAR: begin
                        if (s1_active && s1_hit) begin
                           active_in[s1_idx_ff] = 1'b0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end

               if (issue_cnt_ff < CNT_W'(NUM_SLOTS)) begin
                  ram_rd_en    = 1'b1;
                  s1_valid_in  = 1'b1;
                  s1_idx_in    = issue_cnt_ff[IDX_W-1:0];
                  issue_cnt_in = issue_cnt_ff + 1'b1;
               end else begin
                  s1_valid_in = 1'b0;
                  state_in    = ats_pkg::ST_FINISH;
               end
            end
         end

         ats_pkg::ST_FINISH: begin
            case (job_ff)
               ats_pkg::JOB_TICK: begin
                  // The parked alarm is the final one of this tick.
                  if (!pend_valid_ff) begin
                     state_in = ats_pkg::ST_IDLE;
                  end else if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in        = pend_ff;
                     rsp_in.last   = 1'b1;
                     pend_valid_in = 1'b0;
                     state_in      = ats_pkg::ST_IDLE;
                  end
               end
               ats_pkg::JOB_ARM: begin
                  if (found_valid_ff || free_valid_ff) begin
                     entry_wr.event_id     = cmd_ff.event_id;
                     entry_wr.data         = cmd_ff.aux_data;
                     entry_wr.periodic     = cmd_ff.periodic;
                     entry_wr.period       = cmd_ff.delay;
                     entry_wr.due          = tick_count_ff + {1'b0, cmd_ff.delay};
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = target_idx;
                     active_in[target_idx] = 1'b1;
                     state_in              = ats_pkg::ST_IDLE;
                  end else if (out_free) begin
                     // Table full: one overflow word.
                     rsp_valid_in = 1'b1;
                     rsp_in       = ovf_word;
                     state_in     = ats_pkg::ST_IDLE;
                  end
               end
               default: begin
                  state_in = ats_pkg::ST_IDLE;
               end
            endcase
         end

         default: begin
            state_in = ats_pkg::ST_IDLE;
         end
      endcase

      ram_wr_data = entry_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ats_pkg::ST_IDLE;
         tick_count_ff  <= '0;
         active_ff      <= '0;
         issue_cnt_ff   <= '0;
         s1_valid_ff    <= 1'b0;
         found_valid_ff <= 1'b0;
         free_valid_ff  <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tick_count_ff  <= tick_count_in;
         active_ff      <= active_in;
         issue_cnt_ff   <= issue_cnt_in;
         s1_valid_ff    <= s1_valid_in;
         found_valid_ff <= found_valid_in;
         free_valid_ff  <= free_valid_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      cmd_ff       <= cmd_in;
      s1_idx_ff    <= s1_idx_in;
      found_idx_ff <= found_idx_in;
      free_idx_ff  <= free_idx_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire

FILE: design/ats_checker.sv
`default_nettype none

`include "alarm_table_scheduler_assert.svh"

module ats_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire ats_pkg::req_word_type req_word,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire ats_pkg::rsp_word_type rsp_word
);

   logic real_request;
   logic clean_overflow;

   assign real_request   = req_valid && req_ready &&
                           (req_word.operation != ats_pkg::OP_IGNORED);
   assign clean_overflow = (rsp_word.fired_event == 8'd0) && (rsp_word.fired_data == 32'd0) &&
                           rsp_word.last;

   // An overflow word carries no event and always closes its request.
   `ATS_ASSERT_NOW(a_overflow_word, rsp_valid && rsp_word.overflow, clean_overflow)

   // Every meaningful request starts a table scan, so the block is busy right after.
   `ATS_ASSERT_NEXT(a_busy_after_request, real_request, !req_ready)

   // Result words are only produced while a request is being worked on.
   `ATS_ASSERT_NOW(a_result_from_scan, $rose(rsp_valid), $past(!req_ready))

   // A stalled result word holds.
   `ATS_ASSERT_NEXT(a_result_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

endmodule

bind alarm_table_scheduler ats_checker u_ats_checker (.*);

`default_nettype wire
